// ----- rtl/sha1sh_pkg.sv -----
package sha1sh_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned MSG_WORDS   = 16;
  localparam int unsigned CHAIN_WORDS = 5;
  localparam int unsigned ROUNDS      = 80;
  localparam int unsigned COUNT_W     = 61;

  localparam logic [WORD_W-1:0] IV0 = 32'h67452301;
  localparam logic [WORD_W-1:0] IV1 = 32'hEFCDAB89;
  localparam logic [WORD_W-1:0] IV2 = 32'h98BADCFE;
  localparam logic [WORD_W-1:0] IV3 = 32'h10325476;
  localparam logic [WORD_W-1:0] IV4 = 32'hC3D2E1F0;

  localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } vars_t;

  function automatic word_t iv_word(input logic [2:0] idx);
    word_t w;
    unique case (idx)
      3'd0:    w = IV0;
      3'd1:    w = IV1;
      3'd2:    w = IV2;
      3'd3:    w = IV3;
      default: w = IV4;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/sha1sh_ram.sv -----
module sha1sh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/sha1sh_round.sv -----
module sha1sh_round (
  input  sha1sh_pkg::vars_t cur,
  input  logic [6:0]        rnd,
  input  sha1sh_pkg::word_t w,
  output sha1sh_pkg::vars_t nxt
);

  import sha1sh_pkg::*;

  word_t f;
  word_t k;
  word_t t;

  always_comb begin
    if (rnd < 7'd20) begin
      f = (cur.b & cur.c) | (~cur.b & cur.d);
      k = K0;
    end else if (rnd < 7'd40) begin
      f = cur.b ^ cur.c ^ cur.d;
      k = K1;
    end else if (rnd < 7'd60) begin
      f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
      k = K2;
    end else begin
      f = cur.b ^ cur.c ^ cur.d;
      k = K3;
    end
    t = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;
    nxt.a = t;
    nxt.b = cur.a;
    nxt.c = {cur.b[1:0], cur.b[31:2]};
    nxt.d = cur.c;
    nxt.e = cur.d;
  end

endmodule

// ----- rtl/sha1_stream_hasher.sv -----
// channel  | beat fields                                | handshake
// ---------+--------------------------------------------+--------------------
// in       | in_data_byte, in_byte_valid,               | in_valid/in_ready
//          | in_end_of_message                          |
// out      | out_digest_word, out_word_index,           | out_valid/out_ready
//          | out_last_word                              |
//
// a beat that adds a byte into a partly filled block, without end of message,
// leaves the input ready for the next byte; the 64th byte of a block starts a
// compression: chain load, the rounds, then a chain read-modify-write
// end of message: padding writes (16 - word position) block words, then one
// or two compressions, then each digest word is read from the chain memory
// reset sets the chain valid bits to clear, so the chain reads as the initial
// value at once; no clearing pass
// input stalls during padding, compression or digest read-out; the
// last digest beat waits in the output register while new bytes are taken
module sha1_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  import sha1sh_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_ROUND  = 3'd2;
  localparam logic [2:0] ST_ADD    = 3'd3;
  localparam logic [2:0] ST_PAD    = 3'd4;
  localparam logic [2:0] ST_OUT_RD = 3'd5;
  localparam logic [2:0] ST_OUT_LD = 3'd6;

  localparam int unsigned BLK_AW = $clog2(MSG_WORDS);
  localparam int unsigned CHN_AW = $clog2(CHAIN_WORDS);

  logic [2:0]         state_r, state_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [23:0]        acc_r, acc_nxt;
  logic [6:0]         step_r, step_nxt;
  logic [BLK_AW-1:0]  wp_r, wp_nxt;
  logic [2:0]         oidx_r, oidx_nxt;
  logic               eom_r, eom_nxt;
  logic               fin_r, fin_nxt;
  logic               second_r, second_nxt;
  logic [CHAIN_WORDS-1:0] chain_ok_r, chain_ok_nxt;
  vars_t              vars_r, vars_nxt;
  word_t              w_r [MSG_WORDS];
  logic               out_valid_r, out_valid_nxt;
  word_t              out_word_r, out_word_nxt;
  logic [2:0]         out_idx_r, out_idx_nxt;
  logic               out_last_r, out_last_nxt;

  logic               iv_sel_r;
  logic [CHN_AW-1:0]  ridx_r;

  logic               blk_we;
  logic [BLK_AW-1:0]  blk_waddr, blk_raddr;
  word_t              blk_wdata, blk_q;
  logic               chain_we;
  logic [CHN_AW-1:0]  chain_waddr, chain_raddr;
  word_t              chain_wdata, chain_q, chain_rd;

  logic               in_fire;
  logic [COUNT_W-1:0] cnt_inc;
  word_t              w_cur, w_mix;
  word_t              pad_word;
  vars_t              round_out;
  logic               has_len;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign cnt_inc  = cnt_r + {{(COUNT_W-1){1'b0}}, 1'b1};

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_last_r;

  sha1sh_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MSG_WORDS)
  ) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .raddr (blk_raddr),
    .rdata (blk_q)
  );

  sha1sh_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CHAIN_WORDS)
  ) u_chain_ram (
    .clk   (clk),
    .we    (chain_we),
    .waddr (chain_waddr),
    .wdata (chain_wdata),
    .raddr (chain_raddr),
    .rdata (chain_q)
  );

  // unwritten chain entries read as the initial value
  assign chain_rd = iv_sel_r ? iv_word(ridx_r) : chain_q;

  sha1sh_round u_round (
    .cur (vars_r),
    .rnd (step_r),
    .w   (w_cur),
    .nxt (round_out)
  );

  assign w_mix = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign w_cur = (step_r < 7'd16) ? blk_q : {w_mix[30:0], w_mix[31]};

  // padding word at wp_r
  assign has_len = second_r || (cnt_r[5:2] < 4'd14);

  always_comb begin
    pad_word = '0;
    if (!second_r && (wp_r == cnt_r[5:2])) begin
      unique case (cnt_r[1:0])
        2'd0: pad_word = {PAD_BYTE, 24'h0};
        2'd1: pad_word = {acc_r[7:0], PAD_BYTE, 16'h0};
        2'd2: pad_word = {acc_r[15:0], PAD_BYTE, 8'h0};
        2'd3: pad_word = {acc_r[23:0], PAD_BYTE};
      endcase
    end else if (has_len && (wp_r == 4'd14)) begin
      pad_word = cnt_r[60:29];
    end else if (has_len && (wp_r == 4'd15)) begin
      pad_word = {cnt_r[28:0], 3'b000};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    step_nxt      = step_r;
    wp_nxt        = wp_r;
    oidx_nxt      = oidx_r;
    eom_nxt       = eom_r;
    fin_nxt       = fin_r;
    second_nxt    = second_r;
    chain_ok_nxt  = chain_ok_r;
    vars_nxt      = vars_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;

    blk_we      = 1'b0;
    blk_waddr   = cnt_r[5:2];
    blk_wdata   = {acc_r, in_data_byte};
    blk_raddr   = step_r[BLK_AW-1:0] + 4'd1;
    chain_we    = 1'b0;
    chain_waddr = step_r[2:0] - 3'd1;
    chain_wdata = chain_rd + vars_r.a;
    chain_raddr = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_byte_valid) begin
            cnt_nxt = cnt_inc;
            acc_nxt = {acc_r[15:0], in_data_byte};
            if (cnt_r[1:0] == 2'd3) begin
              blk_we = 1'b1;
            end
          end
          if (in_byte_valid && (cnt_r[5:0] == 6'd63)) begin
            state_nxt = ST_LOAD;
            step_nxt  = '0;
            eom_nxt   = in_end_of_message;
          end else if (in_end_of_message) begin
            state_nxt  = ST_PAD;
            fin_nxt    = 1'b1;
            second_nxt = 1'b0;
            wp_nxt     = in_byte_valid ? cnt_inc[5:2] : cnt_r[5:2];
          end
        end
      end
      ST_LOAD: begin
        if (step_r[2:0] != 3'd5) begin
          chain_raddr = step_r[2:0];
        end
        if (step_r != 7'd0) begin
          vars_nxt = {vars_r.b, vars_r.c, vars_r.d, vars_r.e, chain_rd};
        end
        if (step_r == 7'd5) begin
          blk_raddr = '0;
          state_nxt = ST_ROUND;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 7'd1;
        end
      end
      ST_ROUND: begin
        vars_nxt = round_out;
        if (step_r == 7'(ROUNDS - 1)) begin
          state_nxt = ST_ADD;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 7'd1;
        end
      end
      ST_ADD: begin
        if (step_r[2:0] != 3'd5) begin
          chain_raddr = step_r[2:0];
        end
        if (step_r != 7'd0) begin
          chain_we = 1'b1;
          chain_ok_nxt[chain_waddr] = 1'b1;
          vars_nxt = {vars_r.b, vars_r.c, vars_r.d, vars_r.e, vars_r.a};
        end
        if (step_r == 7'd5) begin
          step_nxt = '0;
          if (!fin_r) begin
            if (eom_r) begin
              state_nxt  = ST_PAD;
              fin_nxt    = 1'b1;
              second_nxt = 1'b0;
              wp_nxt     = cnt_r[5:2];
            end else begin
              state_nxt = ST_IDLE;
            end
          end else if (!second_r && (cnt_r[5:2] >= 4'd14)) begin
            state_nxt  = ST_PAD;
            second_nxt = 1'b1;
            wp_nxt     = '0;
          end else begin
            state_nxt = ST_OUT_RD;
            oidx_nxt  = '0;
          end
        end else begin
          step_nxt = step_r + 7'd1;
        end
      end
      ST_PAD: begin
        blk_we    = 1'b1;
        blk_waddr = wp_r;
        blk_wdata = pad_word;
        if (wp_r == 4'd15) begin
          state_nxt = ST_LOAD;
          step_nxt  = '0;
        end else begin
          wp_nxt = wp_r + 4'd1;
        end
      end
      ST_OUT_RD: begin
        chain_raddr = oidx_r;
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_OUT_LD;
        end
      end
      ST_OUT_LD: begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = chain_rd;
        out_idx_nxt   = oidx_r;
        out_last_nxt  = (oidx_r == 3'd4);
        if (oidx_r == 3'd4) begin
          state_nxt    = ST_IDLE;
          chain_ok_nxt = '0;
          cnt_nxt      = '0;
          eom_nxt      = 1'b0;
          fin_nxt      = 1'b0;
          second_nxt   = 1'b0;
        end else begin
          oidx_nxt  = oidx_r + 3'd1;
          state_nxt = ST_OUT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      step_r      <= '0;
      wp_r        <= '0;
      oidx_r      <= '0;
      eom_r       <= 1'b0;
      fin_r       <= 1'b0;
      second_r    <= 1'b0;
      chain_ok_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      wp_r        <= wp_nxt;
      oidx_r      <= oidx_nxt;
      eom_r       <= eom_nxt;
      fin_r       <= fin_nxt;
      second_r    <= second_nxt;
      chain_ok_r  <= chain_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    vars_r     <= vars_nxt;
    out_word_r <= out_word_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
    iv_sel_r   <= !chain_ok_r[chain_raddr];
    ridx_r     <= chain_raddr;
  end

  // schedule window, newest word at the top
  always_ff @(posedge clk) begin
    if (state_r == ST_ROUND) begin
      for (int i = 0; i < MSG_WORDS - 1; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[MSG_WORDS-1] <= w_cur;
    end
  end

`ifndef SYNTHESIS
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (step_r < 7'(ROUNDS)))
    else $error("round counter out of range");

  a_add_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD && step_r == 7'd5) |=> (chain_ok_r == '1))
    else $error("chain not fully written after update");

  a_out_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT_LD && oidx_r == 3'd4) |=> (chain_ok_r == '0 && cnt_r == '0))
    else $error("chain or count not restored after digest");

  a_second: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> fin_r)
    else $error("second padding block outside finalisation");

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT_LD) |-> !out_valid_r)
    else $error("digest beat overwrites a waiting beat");
`endif

endmodule
